/* rtl/fpami_pkg.sv */
// Shared types, addresses and microcode for the affine matrix inverse.
// Used by the top level and the divider; depends on nothing.
`timescale 1ns / 1ps

package fpami_pkg;

    // scratch memory layout: matrix at 0..15, results and temporaries above
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned PC_W   = 6;

    localparam logic [ADDR_W-1:0] A_INV = 5'd19;
    localparam logic [ADDR_W-1:0] A_TMP = 5'd23;
    localparam logic [ADDR_W-1:0] A_DET = 5'd27;

    localparam logic [PC_W-1:0] LAST_PC = 6'd39;

    // accumulator action of one micro-op
    typedef enum logic [1:0] {
        K_SET = 2'd0,
        K_ADD = 2'd1,
        K_SUB = 2'd2,
        K_DIV = 2'd3
    } t_kind;

    // write-back of the shifted accumulator
    typedef enum logic [1:0] {
        WB_NONE = 2'd0,
        WB_POS  = 2'd1,
        WB_NEG  = 2'd2
    } t_wb;

    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        t_wb               wb;
        logic [ADDR_W-1:0] dst;
    } t_uop;

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RA   = 9'b000000010,
        S_RB   = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_ACC  = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_ORD  = 9'b001000000,
        S_OLD  = 9'b010000000,
        S_OWT  = 9'b100000000
    } t_state;

    function automatic t_uop mk(t_kind k, logic [4:0] a, logic [4:0] b, t_wb w,
                                logic [4:0] d);
        t_uop u;
        u.kind = k;
        u.a    = a;
        u.b    = b;
        u.wb   = w;
        u.dst  = d;
        return u;
    endfunction

    // true when the magnitude of v, taken as signed, is above one lsb
    function automatic logic big_mag(logic [DATA_W-1:0] v);
        return !(v == 32'd0 || v == 32'd1 || v == 32'hFFFF_FFFF);
    endfunction

    // microcode: cofactors, determinant, reciprocal, scaled inverse, translation
    function automatic t_uop uop_rom(logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            6'd0:  u = mk(K_SET, 5'd5,  5'd10, WB_NONE, 5'd0);
            6'd1:  u = mk(K_SUB, 5'd6,  5'd9,  WB_POS,  5'd16);
            6'd2:  u = mk(K_SET, 5'd4,  5'd10, WB_NONE, 5'd0);
            6'd3:  u = mk(K_SUB, 5'd6,  5'd8,  WB_POS,  5'd20);
            6'd4:  u = mk(K_SET, 5'd4,  5'd9,  WB_NONE, 5'd0);
            6'd5:  u = mk(K_SUB, 5'd5,  5'd8,  WB_POS,  5'd24);
            6'd6:  u = mk(K_SET, 5'd0,  5'd16, WB_NONE, 5'd0);
            6'd7:  u = mk(K_SUB, 5'd1,  5'd20, WB_NONE, 5'd0);
            6'd8:  u = mk(K_ADD, 5'd2,  5'd24, WB_POS,  A_DET);
            6'd9:  u = mk(K_DIV, A_DET, A_DET, WB_NONE, A_INV);
            6'd10: u = mk(K_SET, A_INV, 5'd16, WB_POS,  5'd16);
            6'd11: u = mk(K_SET, 5'd1,  5'd10, WB_NONE, 5'd0);
            6'd12: u = mk(K_SUB, 5'd2,  5'd9,  WB_POS,  A_TMP);
            6'd13: u = mk(K_SET, A_INV, A_TMP, WB_NEG,  5'd17);
            6'd14: u = mk(K_SET, 5'd1,  5'd6,  WB_NONE, 5'd0);
            6'd15: u = mk(K_SUB, 5'd2,  5'd5,  WB_POS,  A_TMP);
            6'd16: u = mk(K_SET, A_INV, A_TMP, WB_POS,  5'd18);
            6'd17: u = mk(K_SET, A_INV, 5'd20, WB_NEG,  5'd20);
            6'd18: u = mk(K_SET, 5'd0,  5'd10, WB_NONE, 5'd0);
            6'd19: u = mk(K_SUB, 5'd2,  5'd8,  WB_POS,  A_TMP);
            6'd20: u = mk(K_SET, A_INV, A_TMP, WB_POS,  5'd21);
            6'd21: u = mk(K_SET, 5'd0,  5'd6,  WB_NONE, 5'd0);
            6'd22: u = mk(K_SUB, 5'd2,  5'd4,  WB_POS,  A_TMP);
            6'd23: u = mk(K_SET, A_INV, A_TMP, WB_NEG,  5'd22);
            6'd24: u = mk(K_SET, A_INV, 5'd24, WB_POS,  5'd24);
            6'd25: u = mk(K_SET, 5'd0,  5'd9,  WB_NONE, 5'd0);
            6'd26: u = mk(K_SUB, 5'd1,  5'd8,  WB_POS,  A_TMP);
            6'd27: u = mk(K_SET, A_INV, A_TMP, WB_NEG,  5'd25);
            6'd28: u = mk(K_SET, 5'd0,  5'd5,  WB_NONE, 5'd0);
            6'd29: u = mk(K_SUB, 5'd1,  5'd4,  WB_POS,  A_TMP);
            6'd30: u = mk(K_SET, A_INV, A_TMP, WB_POS,  5'd26);
            6'd31: u = mk(K_SET, 5'd12, 5'd16, WB_NONE, 5'd0);
            6'd32: u = mk(K_ADD, 5'd13, 5'd20, WB_NONE, 5'd0);
            6'd33: u = mk(K_ADD, 5'd14, 5'd24, WB_NEG,  5'd28);
            6'd34: u = mk(K_SET, 5'd12, 5'd17, WB_NONE, 5'd0);
            6'd35: u = mk(K_ADD, 5'd13, 5'd21, WB_NONE, 5'd0);
            6'd36: u = mk(K_ADD, 5'd14, 5'd25, WB_NEG,  5'd29);
            6'd37: u = mk(K_SET, 5'd12, 5'd18, WB_NONE, 5'd0);
            6'd38: u = mk(K_ADD, 5'd13, 5'd22, WB_NONE, 5'd0);
            6'd39: u = mk(K_ADD, 5'd14, 5'd26, WB_NEG,  5'd30);
            default: u = mk(K_SET, 5'd0, 5'd0, WB_NONE, 5'd0);
        endcase
        return u;
    endfunction

endpackage

/* rtl/fpami_div.sv */
// Bit-serial restoring divider: 2^(2*FRAC_BITS) / divisor, truncating, signed.
// Depends on fpami_pkg for the data width.
`timescale 1ns / 1ps

module fpami_div #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fpami_pkg::DATA_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [fpami_pkg::DATA_W-1:0]  o_quot
);
    localparam int unsigned NUM_W = 2 * FRAC_BITS + 1;
    localparam int unsigned CW    = $clog2(NUM_W + 1);
    localparam int unsigned DW    = fpami_pkg::DATA_W;

    logic           r_busy;
    logic [CW-1:0]  r_cnt;
    logic [DW-1:0]  r_d;
    logic [DW-1:0]  r_rem;
    logic [NUM_W-1:0] r_q;
    logic           r_neg;
    logic           r_zero;
    logic [DW:0]    trial;
    logic [DW-1:0]  quot;

    // the numerator has a single one bit, its msb, fed in on the first step
    assign trial = {r_rem, (r_cnt == CW'(NUM_W))};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NUM_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // one quotient bit per cycle on magnitudes
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d    <= i_divisor[DW-1] ? (DW'(0) - i_divisor) : i_divisor;
            r_neg  <= i_divisor[DW-1];
            r_zero <= (i_divisor == '0);
            r_rem  <= '0;
            r_q    <= '0;
        end else if (r_busy && r_cnt != '0) begin
            if (trial >= {1'b0, r_d}) begin
                r_rem <= DW'(trial - {1'b0, r_d});
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DW-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign quot   = DW'(r_q);
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_zero ? '0 : (r_neg ? (DW'(0) - quot) : quot);

endmodule

/* rtl/fixed_point_affine_matrix_invert_top.sv */
// Fixed-point affine 4x4 matrix inverse: top level with sequencer and shared MAC.
// Depends on fpami_pkg and fpami_div.
// A load request writes its element into the matrix store; index 15 then runs 39 micro-ops
// on the single multiplier plus one divide micro-op, then gives 16 results.
// A rejected matrix gives its single result on the cycle after the request.
// Throughput: the input is stalled from the index 15 request until the last result.
// Reset (synchronous, active low) clears the sequencer; the matrix store is not cleared.
`timescale 1ns / 1ps

module fixed_point_affine_matrix_invert_top #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_element_value,
    input  logic [3:0]  i_element_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_value,
    output logic [3:0]  o_result_index,
    output logic        o_accepted,
    output logic        o_last_result
);
    localparam int unsigned DW = fpami_pkg::DATA_W;
    localparam int unsigned AW = fpami_pkg::ADDR_W;
    localparam logic [DW-1:0] ONE_FX = DW'(1) << FRAC_BITS;

    fpami_pkg::t_state r_state;
    logic [fpami_pkg::PC_W-1:0] r_pc;
    logic [3:0]     r_k;
    logic [DW-1:0]  r_mem [2**AW];
    logic [DW-1:0]  r_rd;
    logic [DW-1:0]  r_opa;
    logic [DW-1:0]  r_prod;
    logic [DW-1:0]  r_acc;
    logic [3:0]     r_bad;
    logic [DW-1:0]  r_out_value;
    logic [3:0]     r_out_index;
    logic           r_out_acc;
    logic           r_out_last;

    fpami_pkg::t_uop uop;
    logic           in_req;
    logic           reject;
    logic [3:0]     n_bad;
    logic [DW-1:0]  n_acc;
    logic [DW-1:0]  shifted;
    logic [DW-1:0]  wb_data;
    logic           we;
    logic [AW-1:0]  wa;
    logic [DW-1:0]  wd;
    logic [AW-1:0]  ra;
    logic           div_start;
    logic           div_done;
    logic [DW-1:0]  div_quot;

    assign uop    = fpami_pkg::uop_rom(r_pc);
    assign in_req = i_in_valid && (r_state == fpami_pkg::S_IDLE);

    // affine check flags for elements 3, 7, 11 and 15, kept at load time
    always_comb begin
        n_bad = r_bad;
        unique case (i_element_index)
            4'd3:    n_bad[0] = fpami_pkg::big_mag(i_element_value);
            4'd7:    n_bad[1] = fpami_pkg::big_mag(i_element_value);
            4'd11:   n_bad[2] = fpami_pkg::big_mag(i_element_value);
            4'd15:   n_bad[3] = fpami_pkg::big_mag(i_element_value - ONE_FX);
            default: n_bad = r_bad;
        endcase
    end
    assign reject = |n_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad <= '0;
        end else if (in_req) begin
            r_bad <= n_bad;
        end
    end

    // accumulator step and shifted write-back value
    always_comb begin
        case (uop.kind)
            fpami_pkg::K_SET: n_acc = r_prod;
            fpami_pkg::K_ADD: n_acc = r_acc + r_prod;
            fpami_pkg::K_SUB: n_acc = r_acc - r_prod;
            default:          n_acc = r_acc;
        endcase
        shifted = DW'($signed(n_acc) >>> FRAC_BITS);
        wb_data = (uop.wb == fpami_pkg::WB_NEG) ? (DW'(0) - shifted) : shifted;
    end

    // memory write port: loads when idle, results while busy
    always_comb begin
        we = 1'b0;
        wa = uop.dst;
        wd = wb_data;
        if (in_req) begin
            we = 1'b1;
            wa = {1'b0, i_element_index};
            wd = i_element_value;
        end else if (r_state == fpami_pkg::S_ACC) begin
            we = (uop.wb != fpami_pkg::WB_NONE);
        end else if (r_state == fpami_pkg::S_DIV) begin
            we = div_done;
            wd = div_quot;
        end
    end

    // memory read address
    always_comb begin
        if (r_state == fpami_pkg::S_RB) begin
            ra = uop.b;
        end else if (r_state == fpami_pkg::S_ORD) begin
            ra = {1'b1, r_k};
        end else begin
            ra = uop.a;
        end
    end

    // scratch memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd <= r_mem[ra];
    end

    // operand, product and accumulator registers
    always_ff @(posedge i_clk) begin
        if (r_state == fpami_pkg::S_RB) begin
            r_opa <= r_rd;
        end
        if (r_state == fpami_pkg::S_MUL) begin
            r_prod <= DW'(r_opa * r_rd);
        end
        if (r_state == fpami_pkg::S_ACC) begin
            r_acc <= n_acc;
        end
    end

    assign div_start = (r_state == fpami_pkg::S_RB) && (uop.kind == fpami_pkg::K_DIV);

    fpami_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (r_rd),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpami_pkg::S_IDLE;
            r_pc    <= '0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                fpami_pkg::S_IDLE: begin
                    if (in_req && i_element_index == 4'd15) begin
                        r_pc    <= '0;
                        r_k     <= '0;
                        r_state <= reject ? fpami_pkg::S_OWT : fpami_pkg::S_RA;
                    end
                end
                fpami_pkg::S_RA:  r_state <= fpami_pkg::S_RB;
                fpami_pkg::S_RB: begin
                    r_state <= (uop.kind == fpami_pkg::K_DIV) ? fpami_pkg::S_DIV
                                                               : fpami_pkg::S_MUL;
                end
                fpami_pkg::S_MUL: r_state <= fpami_pkg::S_ACC;
                fpami_pkg::S_ACC, fpami_pkg::S_DIV: begin
                    if (r_state == fpami_pkg::S_ACC || div_done) begin
                        r_pc    <= r_pc + 1'b1;
                        r_state <= (r_pc == fpami_pkg::LAST_PC) ? fpami_pkg::S_ORD
                                                                 : fpami_pkg::S_RA;
                    end
                end
                fpami_pkg::S_ORD: r_state <= fpami_pkg::S_OLD;
                fpami_pkg::S_OLD: r_state <= fpami_pkg::S_OWT;
                fpami_pkg::S_OWT: begin
                    if (!i_out_stall) begin
                        if (r_out_last) begin
                            r_state <= fpami_pkg::S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= fpami_pkg::S_ORD;
                        end
                    end
                end
                default: r_state <= fpami_pkg::S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == fpami_pkg::S_IDLE && in_req && i_element_index == 4'd15 && reject) begin
            r_out_value <= '0;
            r_out_index <= '0;
            r_out_acc   <= 1'b0;
            r_out_last  <= 1'b1;
        end else if (r_state == fpami_pkg::S_OLD) begin
            if (r_k == 4'd15) begin
                r_out_value <= ONE_FX;
            end else if (r_k[1:0] == 2'd3) begin
                r_out_value <= '0;
            end else begin
                r_out_value <= r_rd;
            end
            r_out_index <= r_k;
            r_out_acc   <= 1'b1;
            r_out_last  <= (r_k == 4'd15);
        end
    end

    assign o_in_stall     = (r_state != fpami_pkg::S_IDLE);
    assign o_out_valid    = (r_state == fpami_pkg::S_OWT);
    assign o_result_value = r_out_value;
    assign o_result_index = r_out_index;
    assign o_accepted     = r_out_acc;
    assign o_last_result  = r_out_last;

endmodule

/* rtl/fpami_checker.sv */
// Port-level checks for the affine matrix inverse, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module fpami_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_result_value,
    input logic [3:0]  o_result_index,
    input logic        o_accepted,
    input logic        o_last_result
);

    // no new request taken while a result is pending
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value))
        else $error("stalled result changed");

    // rejected matrix gives a single zero result
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_accepted |-> o_last_result && o_result_value == 32'd0)
        else $error("bad rejected result");

    // last flag sits on index 15 of an inverse
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> (o_last_result == (o_result_index == 4'd15)))
        else $error("last flag misplaced");

endmodule

bind fixed_point_affine_matrix_invert_top fpami_checker u_fpami_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value),
    .o_result_index (o_result_index),
    .o_accepted     (o_accepted),
    .o_last_result  (o_last_result)
);
